@@ sv/cbtb_pkg.sv @@
// Shared types and constants for the coalescing branch trace buffer.
package cbtb_pkg;

    localparam int unsigned TRACE_DEPTH_DEF = 32;
    localparam logic [31:0] COUNT_MAX       = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_RECORD = 2'd0,
        KIND_DUMP   = 2'd1,
        KIND_CLEAR  = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REC_RD,
        ST_REC_UPD,
        ST_DUMP
    } t_state;

    typedef struct packed {
        logic [15:0] src_seg;
        logic [15:0] src_off;
        logic [15:0] tgt_seg;
        logic [15:0] tgt_off;
        logic        intr;
    } t_branch;

    typedef struct packed {
        t_branch     br;
        logic [31:0] count;
    } t_entry;

    localparam int unsigned ENTRY_W = $bits(t_entry);

endpackage

@@ sv/coalescing_branch_trace_buffer.sv @@
// Top level: sequencer, pointers and fill count around the entry RAM and compare unit.
// A record beat, once it is taken, keeps busy high while the newest entry is
// read from the single-port-read RAM, then compared and either bumped in place or a new
// entry written. A dump of n entries keeps busy high while it reads them, one read per
// cycle; each result is shown on the cycle after its read, so the final one appears in
// the first cycle after busy falls. An empty dump gives its single result on the next
// cycle without raising busy. Clear, ignored records and unused kinds never raise busy.
// Results cannot be held off; o_strobe marks each for exactly one cycle. Validity is a
// fill count, so reset and clear are immediate with no sweep of the RAM.
module coalescing_branch_trace_buffer
    import cbtb_pkg::*;
#(
    parameter int unsigned TRACE_DEPTH = TRACE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_source_segment,
    input  logic [15:0] i_source_offset,
    input  logic [15:0] i_target_segment,
    input  logic [15:0] i_target_offset,
    input  logic        i_by_interrupt,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    output logic        o_strobe,
    output logic [15:0] o_out_source_segment,
    output logic [15:0] o_out_source_offset,
    output logic [15:0] o_out_target_segment,
    output logic [15:0] o_out_target_offset,
    output logic        o_out_interrupt,
    output logic [31:0] o_repeat_count,
    output logic        o_entry_valid,
    output logic        o_last
);

    localparam int unsigned AW = $clog2(TRACE_DEPTH);
    localparam int unsigned FW = $clog2(TRACE_DEPTH + 1);
    localparam logic [AW-1:0] IDX_LAST = AW'(TRACE_DEPTH - 1);
    localparam logic [FW-1:0] FILL_FULL = FW'(TRACE_DEPTH);

    t_state        r_state, n_state;
    logic          r_trace_en, n_trace_en;
    logic [AW-1:0] r_ptr, n_ptr;
    logic [FW-1:0] r_fill, n_fill;
    logic [AW-1:0] r_idx, n_idx;
    logic [FW-1:0] r_left, n_left;
    logic          r_pend, n_pend;
    logic          r_pend_valid, n_pend_valid;
    logic          r_pend_last, n_pend_last;
    t_branch       r_br, n_br;

    logic          accept;
    logic [AW-1:0] newest;
    logic [AW-1:0] ptr_inc;
    logic [AW-1:0] idx_inc;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    t_entry        ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry        rd_entry;
    t_branch       in_br;
    logic          hit;
    logic [31:0]   count_inc;

    assign accept  = start && !busy;
    assign busy    = (r_state != ST_IDLE);
    assign newest  = (r_ptr == '0) ? IDX_LAST : r_ptr - AW'(1);
    assign ptr_inc = (r_ptr == IDX_LAST) ? '0 : r_ptr + AW'(1);
    assign idx_inc = (r_idx == IDX_LAST) ? '0 : r_idx + AW'(1);
    assign rd_entry = t_entry'(ram_rdata);

    assign in_br.src_seg = i_source_segment;
    assign in_br.src_off = i_source_offset;
    assign in_br.tgt_seg = i_target_segment;
    assign in_br.tgt_off = i_target_offset;
    assign in_br.intr    = i_by_interrupt;

    cbtb_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TRACE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cbtb_match u_match (
        .i_entry       (rd_entry),
        .i_branch      (r_br),
        .i_entry_valid (r_fill != '0),
        .o_hit         (hit),
        .o_count_inc   (count_inc)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_trace_en   <= 1'b0;
            r_ptr        <= '0;
            r_fill       <= '0;
            r_idx        <= '0;
            r_left       <= '0;
            r_pend       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_pend_last  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_trace_en   <= n_trace_en;
            r_ptr        <= n_ptr;
            r_fill       <= n_fill;
            r_idx        <= n_idx;
            r_left       <= n_left;
            r_pend       <= n_pend;
            r_pend_valid <= n_pend_valid;
            r_pend_last  <= n_pend_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_br <= n_br;
    end

    always_comb begin
        n_state      = r_state;
        n_trace_en   = r_trace_en;
        n_ptr        = r_ptr;
        n_fill       = r_fill;
        n_idx        = r_idx;
        n_left       = r_left;
        n_pend       = 1'b0;
        n_pend_valid = 1'b0;
        n_pend_last  = 1'b0;
        n_br         = r_br;
        ram_we       = 1'b0;
        ram_waddr    = r_ptr;
        ram_wdata    = '0;
        ram_re       = 1'b0;
        ram_raddr    = newest;

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    unique case (t_kind'(i_kind))
                        KIND_RECORD: begin
                            if (r_trace_en) begin
                                n_br    = in_br;
                                n_state = ST_REC_RD;
                            end
                        end
                        KIND_DUMP: begin
                            if (r_fill == '0) begin
                                n_pend      = 1'b1;
                                n_pend_last = 1'b1;
                            end else begin
                                n_idx   = (r_fill == FILL_FULL) ? r_ptr : '0;
                                n_left  = r_fill;
                                n_state = ST_DUMP;
                            end
                        end
                        KIND_CLEAR: begin
                            n_ptr  = '0;
                            n_fill = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_REC_RD: begin
                ram_re    = 1'b1;
                ram_raddr = newest;
                n_state   = ST_REC_UPD;
            end
            ST_REC_UPD: begin
                ram_we = 1'b1;
                if (hit) begin
                    ram_waddr       = newest;
                    ram_wdata.br    = rd_entry.br;
                    ram_wdata.count = count_inc;
                end else begin
                    ram_waddr       = r_ptr;
                    ram_wdata.br    = r_br;
                    ram_wdata.count = 32'd1;
                    n_ptr           = ptr_inc;
                    n_fill          = (r_fill == FILL_FULL) ? r_fill : r_fill + FW'(1);
                end
                n_state = ST_IDLE;
            end
            ST_DUMP: begin
                ram_re       = 1'b1;
                ram_raddr    = r_idx;
                n_idx        = idx_inc;
                n_left       = r_left - FW'(1);
                n_pend       = 1'b1;
                n_pend_valid = 1'b1;
                n_pend_last  = (r_left == FW'(1));
                if (r_left == FW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg_we) begin
            n_trace_en = i_cfg_wdata;
            if (!i_cfg_wdata) begin
                n_ptr  = '0;
                n_fill = '0;
            end
        end
    end

    // empty dump beat shows zeroed fields
    assign o_strobe             = r_pend;
    assign o_entry_valid        = r_pend_valid;
    assign o_last               = r_pend_last;
    assign o_out_source_segment = r_pend_valid ? rd_entry.br.src_seg : '0;
    assign o_out_source_offset  = r_pend_valid ? rd_entry.br.src_off : '0;
    assign o_out_target_segment = r_pend_valid ? rd_entry.br.tgt_seg : '0;
    assign o_out_target_offset  = r_pend_valid ? rd_entry.br.tgt_off : '0;
    assign o_out_interrupt      = r_pend_valid ? rd_entry.br.intr : 1'b0;
    assign o_repeat_count       = r_pend_valid ? rd_entry.count : '0;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_FULL)
        else $error("fill count beyond store depth");

    a_dump_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DUMP) |-> (r_left != '0) && (r_left <= r_fill))
        else $error("dump count out of range");

    a_rec_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_kind == KIND_RECORD) && !r_trace_en) |=> !busy && !o_strobe)
        else $error("record taken while tracing disabled");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_entry_valid) |-> o_last && ($past(r_fill) == '0))
        else $error("empty dump beat from non-empty store");

endmodule

@@ sv/cbtb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module cbtb_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/cbtb_match.sv @@
// Shared compare and count increment unit for coalescing a branch into the newest entry.
module cbtb_match
    import cbtb_pkg::*;
(
    input  t_entry      i_entry,
    input  t_branch     i_branch,
    input  logic        i_entry_valid,
    output logic        o_hit,
    output logic [31:0] o_count_inc
);

    assign o_hit       = i_entry_valid && (i_entry.br == i_branch) && (i_entry.count != COUNT_MAX);
    assign o_count_inc = i_entry.count + 32'd1;

endmodule
